[rtl/mobd_pkg.sv]
// Package for the masked one-bit decoder: sizes, request codes, the table's
// start pattern and the command and status structs between modules.
// No dependencies.
`timescale 1ns / 1ps

package mobd_pkg;

   // Masking order and table size.
   localparam int ORDER      = 3;
   localparam int NUM_SHARES = ORDER + 1;
   localparam int TABLE_LOG  = 7;
   localparam int TABLE_BITS = 1 << TABLE_LOG;
   localparam int WORD_BITS  = 64;
   localparam int NUM_WORDS  = (TABLE_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int SLICE_BITS = (TABLE_BITS < WORD_BITS) ? TABLE_BITS : WORD_BITS;

   // Index and counter widths.
   localparam int SIDX_W = $clog2(NUM_SHARES);
   localparam int WIDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   // Field widths.
   localparam int SHARE_W    = 12;
   localparam int OUT_IDX_W  = 2;
   localparam int BOOL_W     = 16;
   localparam int REQ_DATA_W = ((SHARE_W + WORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((OUT_IDX_W + BOOL_W + 7) / 8) * 8;

   // Modulus switch divider sizes.
   localparam int NUM_W = SHARE_W + TABLE_LOG + 2;
   localparam int DEN_W = SHARE_W + 1;
   localparam int REM_W = DEN_W + 1;
   localparam int CNT_W = $clog2(NUM_W);

   localparam logic [SHARE_W-1:0] MODULUS_RESET = 12'd3329;

   // Request kinds carried in tuser.
   localparam logic REQ_SHARE  = 1'b0;
   localparam logic REQ_RANDOM = 1'b1;

   // Start pattern of table share zero: its middle half is set.
   function automatic logic [TABLE_BITS-1:0] table_start_row();
      logic [TABLE_BITS-1:0] v;
      v = '0;
      for (int b = TABLE_BITS / 4; b < 3 * (TABLE_BITS / 4); b++) begin
         v[b] = 1'b1;
      end
      return v;
   endfunction

   // Commands from the sequencer to the table.
   typedef struct packed {
      logic                  init;
      logic                  rot_start;
      logic [TABLE_LOG-1:0]  rot_amt;
      logic                  refresh;
      logic [SIDX_W-1:0]     row;
      logic [WIDX_W-1:0]     word;
      logic [WORD_BITS-1:0]  data;
   } tbl_cmd_type;

   // Table status back to the sequencer.
   typedef struct packed {
      logic busy;
      logic rot_done;
   } tbl_status_type;

endpackage

[rtl/masked_one_bit_decoder.sv]
// Top level of the masked one-bit decoder: request sequencer, modulus
// register, switched shares and boolean share accumulators.
// Depends on mobd_pkg, mobd_switch and mobd_table.
`timescale 1ns / 1ps

// Each share request runs through the switch divider, which makes one quotient
// bit per cycle. A rotation of the table makes one pass of the shared rotator
// per share; random words are not taken while it runs. The last refresh word
// leads to the bit pick, then the final masking words; the NUM_SHARES results
// then leave at one per cycle while rsp_tready is high and no request is taken.
// Reset is synchronous, active high: modulus 3329, table at its start pattern.
module masked_one_bit_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: share_value [11:0], random_word [75:12], zero fill [79:76]
   input  logic [mobd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: req_type [0]
   input  logic                              req_tuser,
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: share_index [1:0], bool_share [17:2], zero fill [23:18]
   output logic [mobd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   // Modulus register write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mobd_pkg::SHARE_W-1:0]      csr_data
);

   typedef enum logic [6:0] {
      ST_LOAD    = 7'b0000001,
      ST_DIV     = 7'b0000010,
      ST_ROT     = 7'b0000100,
      ST_REFRESH = 7'b0001000,
      ST_PICK    = 7'b0010000,
      ST_FINAL   = 7'b0100000,
      ST_EMIT    = 7'b1000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [mobd_pkg::SHARE_W-1:0]      modulus_ff, modulus_in;
   logic [mobd_pkg::TABLE_LOG-1:0]    sw_ff [mobd_pkg::NUM_SHARES];
   logic [mobd_pkg::TABLE_LOG-1:0]    sw_in [mobd_pkg::NUM_SHARES];
   logic [mobd_pkg::BOOL_W-1:0]       acc_ff [mobd_pkg::NUM_SHARES];
   logic [mobd_pkg::BOOL_W-1:0]       acc_in [mobd_pkg::NUM_SHARES];
   logic [mobd_pkg::SIDX_W-1:0]       share_cnt_ff, share_cnt_in;
   logic [mobd_pkg::SIDX_W-1:0]       row_cnt_ff, row_cnt_in;
   logic [mobd_pkg::SIDX_W-1:0]       round_cnt_ff, round_cnt_in;
   logic [mobd_pkg::WIDX_W-1:0]       word_cnt_ff, word_cnt_in;
   logic [mobd_pkg::SIDX_W-1:0]       emit_idx_ff, emit_idx_in;

   logic                              req_accept;
   logic                              rsp_accept;
   logic [mobd_pkg::SHARE_W-1:0]      req_share;
   logic [mobd_pkg::WORD_BITS-1:0]    req_word;
   logic [mobd_pkg::SIDX_W-1:0]       round_next;

   logic                              div_start;
   logic                              div_done;
   logic [mobd_pkg::TABLE_LOG-1:0]    div_result;
   mobd_pkg::tbl_cmd_type             tbl_cmd;
   mobd_pkg::tbl_status_type          tbl_status;
   logic [mobd_pkg::NUM_SHARES-1:0]   pick_bits;

   assign req_share  = req_tdata[mobd_pkg::SHARE_W-1:0];
   assign req_word   = req_tdata[mobd_pkg::SHARE_W +: mobd_pkg::WORD_BITS];
   assign req_tready = (state_ff == ST_LOAD) || (state_ff == ST_REFRESH)
                       || (state_ff == ST_FINAL);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign round_next = round_cnt_ff + 1'b1;

   // Modulus register; writes must arrive only while the block is idle, which the block itself does not enforce.
   assign csr_ready  = 1'b1;
   assign modulus_in = (csr_valid && csr_ready) ? csr_data : modulus_ff;

   // Sequencer over loading, rounds, final masking and result delivery.
   always_comb begin
      state_in     = state_ff;
      sw_in        = sw_ff;
      acc_in       = acc_ff;
      share_cnt_in = share_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      round_cnt_in = round_cnt_ff;
      word_cnt_in  = word_cnt_ff;
      emit_idx_in  = emit_idx_ff;
      div_start    = 1'b0;
      tbl_cmd      = '0;
      tbl_cmd.row  = row_cnt_ff;
      tbl_cmd.word = word_cnt_ff;
      tbl_cmd.data = req_word;
      case (state_ff)
         ST_LOAD: begin
            // A random word while loading is dropped.
            if (req_accept && (req_tuser == mobd_pkg::REQ_SHARE)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               sw_in[share_cnt_ff] = div_result;
               if (share_cnt_ff == mobd_pkg::SIDX_W'(mobd_pkg::NUM_SHARES - 1)) begin
                  share_cnt_in      = '0;
                  row_cnt_in        = '0;
                  round_cnt_in      = '0;
                  word_cnt_in       = '0;
                  tbl_cmd.rot_start = 1'b1;
                  tbl_cmd.rot_amt   = sw_ff[0];
                  state_in          = ST_ROT;
               end else begin
                  share_cnt_in = share_cnt_ff + 1'b1;
                  state_in     = ST_LOAD;
               end
            end
         end
         ST_ROT: begin
            if (tbl_status.rot_done) begin
               state_in = ST_REFRESH;
            end
         end
         ST_REFRESH: begin
            // A share request between rounds is dropped.
            if (req_accept && (req_tuser == mobd_pkg::REQ_RANDOM)) begin
               tbl_cmd.refresh = 1'b1;
               if (word_cnt_ff == mobd_pkg::WIDX_W'(mobd_pkg::NUM_WORDS - 1)) begin
                  word_cnt_in = '0;
                  if (row_cnt_ff == mobd_pkg::SIDX_W'(mobd_pkg::ORDER - 1)) begin
                     row_cnt_in = '0;
                     if (round_cnt_ff == mobd_pkg::SIDX_W'(mobd_pkg::ORDER - 1)) begin
                        round_cnt_in = '0;
                        state_in     = ST_PICK;
                     end else begin
                        // The next rotation amount comes from the following
                        // switched share.
                        round_cnt_in      = round_next;
                        tbl_cmd.rot_start = 1'b1;
                        tbl_cmd.rot_amt   = sw_ff[round_next];
                        state_in          = ST_ROT;
                     end
                  end else begin
                     row_cnt_in = row_cnt_ff + 1'b1;
                  end
               end else begin
                  word_cnt_in = word_cnt_ff + 1'b1;
               end
            end
         end
         ST_PICK: begin
            // The table has taken the last refresh word; read out the bits.
            for (int i = 0; i < mobd_pkg::NUM_SHARES; i++) begin
               acc_in[i] = mobd_pkg::BOOL_W'(pick_bits[i]);
            end
            share_cnt_in = '0;
            state_in     = ST_FINAL;
         end
         ST_FINAL: begin
            if (req_accept && (req_tuser == mobd_pkg::REQ_RANDOM)) begin
               acc_in[share_cnt_ff] = acc_ff[share_cnt_ff]
                                      ^ req_word[mobd_pkg::BOOL_W-1:0];
               acc_in[mobd_pkg::ORDER] = acc_ff[mobd_pkg::ORDER]
                                         ^ req_word[mobd_pkg::BOOL_W-1:0];
               if (share_cnt_ff == mobd_pkg::SIDX_W'(mobd_pkg::ORDER - 1)) begin
                  share_cnt_in = '0;
                  emit_idx_in  = '0;
                  tbl_cmd.init = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  share_cnt_in = share_cnt_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_accept) begin
               if (rsp_tlast) begin
                  emit_idx_in = '0;
                  state_in    = ST_LOAD;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         modulus_ff   <= mobd_pkg::MODULUS_RESET;
         share_cnt_ff <= '0;
         row_cnt_ff   <= '0;
         round_cnt_ff <= '0;
         word_cnt_ff  <= '0;
         emit_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         share_cnt_ff <= share_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         round_cnt_ff <= round_cnt_in;
         word_cnt_ff  <= word_cnt_in;
         emit_idx_ff  <= emit_idx_in;
      end
      sw_ff  <= sw_in;
      acc_ff <= acc_in;
   end

   mobd_switch u_switch (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .share   (req_share),
      .modulus (modulus_ff),
      .done    (div_done),
      .result  (div_result)
   );

   mobd_table u_table (
      .clock     (clock),
      .reset     (reset),
      .cmd       (tbl_cmd),
      .pick_pos  (sw_ff[mobd_pkg::ORDER]),
      .status    (tbl_status),
      .pick_bits (pick_bits)
   );

   // Result delivery.
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tlast  = (emit_idx_ff == mobd_pkg::SIDX_W'(mobd_pkg::ORDER));
   assign rsp_tdata  = mobd_pkg::RSP_DATA_W'({acc_ff[emit_idx_ff],
                                              mobd_pkg::OUT_IDX_W'(emit_idx_ff)});

`ifndef SYNTHESIS
   // No request is taken while results are being delivered.
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request ready while results pending");

   // While waiting on a rotation the table must be rotating.
   a_rot_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT) |-> tbl_status.busy)
      else $error("rotation wait without table activity");

   // The result index never runs past the last share.
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (emit_idx_ff <= mobd_pkg::SIDX_W'(mobd_pkg::ORDER)))
      else $error("result index out of range");

   // After the last result the block takes shares again.
   a_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_tlast) |=> (req_tready && (state_ff == ST_LOAD)))
      else $error("block not back to loading after last result");
`endif

endmodule

[rtl/mobd_switch.sv]
// Modulus switch unit: computes ((s << (TABLE_LOG+1)) + q) / (2q) one
// quotient bit per cycle with a restoring divider. Depends on mobd_pkg.
`timescale 1ns / 1ps

module mobd_switch (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mobd_pkg::SHARE_W-1:0]      share,
   input  logic [mobd_pkg::SHARE_W-1:0]      modulus,
   output logic                              done,
   output logic [mobd_pkg::TABLE_LOG-1:0]    result
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [mobd_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [mobd_pkg::NUM_W-1:0]        num_ff, num_in;
   logic [mobd_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [mobd_pkg::DEN_W-1:0]        den_ff, den_in;
   logic [mobd_pkg::TABLE_LOG-1:0]    quo_ff, quo_in;
   logic                              zero_ff, zero_in;

   logic [mobd_pkg::REM_W-1:0]        trial;
   logic                              fits;

   // One restoring step: bring down the next numerator bit and try a subtract.
   assign trial = {rem_ff[mobd_pkg::REM_W-2:0], num_ff[mobd_pkg::NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      zero_in = zero_ff;
      if (start) begin
         num_in  = (mobd_pkg::NUM_W'(share) << (mobd_pkg::TABLE_LOG + 1))
                   + mobd_pkg::NUM_W'(modulus);
         rem_in  = '0;
         den_in  = {modulus, 1'b0};
         quo_in  = '0;
         zero_in = (modulus == '0);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, den_ff}) : trial;
         // Only the low quotient bits are kept; older bits shift out.
         quo_in = {quo_ff[mobd_pkg::TABLE_LOG-2:0], fits};
         num_in = num_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mobd_pkg::CNT_W'(mobd_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
   end

   // A zero modulus switches every share to zero.
   assign done   = done_ff;
   assign result = zero_ff ? '0 : quo_ff;

endmodule

[rtl/mobd_table.sv]
// Masked table store: ORDER+1 table shares, one shared barrel rotator that
// visits the shares one per cycle, the word refresh and the bit pick.
// Depends on mobd_pkg.
`timescale 1ns / 1ps

module mobd_table (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mobd_pkg::tbl_cmd_type                 cmd,
   input  logic [mobd_pkg::TABLE_LOG-1:0]        pick_pos,
   output mobd_pkg::tbl_status_type              status,
   output logic [mobd_pkg::NUM_SHARES-1:0]       pick_bits
);

   logic [mobd_pkg::TABLE_BITS-1:0] rows_ff [mobd_pkg::NUM_SHARES];
   logic [mobd_pkg::TABLE_BITS-1:0] rows_in [mobd_pkg::NUM_SHARES];
   logic                            busy_ff, busy_in;
   logic [mobd_pkg::SIDX_W-1:0]     row_ff, row_in;
   logic [mobd_pkg::TABLE_LOG-1:0]  amt_ff, amt_in;
   logic                            last_row;

   // Rotate right by a variable amount, one stage per amount bit.
   function automatic logic [mobd_pkg::TABLE_BITS-1:0] rotr(
      input logic [mobd_pkg::TABLE_BITS-1:0] value,
      input logic [mobd_pkg::TABLE_LOG-1:0]  amount
   );
      logic [mobd_pkg::TABLE_BITS-1:0] v;
      v = value;
      for (int b = 0; b < mobd_pkg::TABLE_LOG; b++) begin
         if (amount[b]) begin
            v = (v >> (1 << b)) | (v << (mobd_pkg::TABLE_BITS - (1 << b)));
         end
      end
      return v;
   endfunction

   assign last_row = (row_ff == mobd_pkg::SIDX_W'(mobd_pkg::NUM_SHARES - 1));

   always_comb begin
      rows_in = rows_ff;
      busy_in = busy_ff;
      row_in  = row_ff;
      amt_in  = amt_ff;
      if (cmd.init) begin
         // Back to the start pattern for the next run.
         for (int i = 0; i < mobd_pkg::NUM_SHARES; i++) begin
            rows_in[i] = '0;
         end
         rows_in[0] = mobd_pkg::table_start_row();
         busy_in    = 1'b0;
      end else if (busy_ff) begin
         // The rotator serves one table share per cycle.
         rows_in[row_ff] = rotr(rows_ff[row_ff], amt_ff);
         row_in          = row_ff + 1'b1;
         if (last_row) begin
            busy_in = 1'b0;
         end
      end else begin
         if (cmd.refresh) begin
            // The word goes into the chosen share and into the last share.
            rows_in[cmd.row][cmd.word * mobd_pkg::SLICE_BITS +: mobd_pkg::SLICE_BITS] =
               rows_ff[cmd.row][cmd.word * mobd_pkg::SLICE_BITS +: mobd_pkg::SLICE_BITS]
               ^ cmd.data[mobd_pkg::SLICE_BITS-1:0];
            rows_in[mobd_pkg::ORDER][cmd.word * mobd_pkg::SLICE_BITS +: mobd_pkg::SLICE_BITS] =
               rows_ff[mobd_pkg::ORDER][cmd.word * mobd_pkg::SLICE_BITS +: mobd_pkg::SLICE_BITS]
               ^ cmd.data[mobd_pkg::SLICE_BITS-1:0];
         end
         // A rotation may start with the last refresh word of a round; it then
         // works on the refreshed rows from the next cycle on.
         if (cmd.rot_start) begin
            busy_in = 1'b1;
            row_in  = '0;
            amt_in  = cmd.rot_amt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mobd_pkg::NUM_SHARES; i++) begin
            rows_ff[i] <= '0;
         end
         rows_ff[0] <= mobd_pkg::table_start_row();
         busy_ff    <= 1'b0;
         row_ff     <= '0;
      end else begin
         rows_ff <= rows_in;
         busy_ff <= busy_in;
         row_ff  <= row_in;
      end
      amt_ff <= amt_in;
   end

   // Bit at the pick position from every table share.
   always_comb begin
      for (int i = 0; i < mobd_pkg::NUM_SHARES; i++) begin
         pick_bits[i] = rows_ff[i][pick_pos];
      end
   end

   assign status.busy     = busy_ff;
   assign status.rot_done = busy_ff && last_row;

endmodule

[tb/masked_one_bit_decoder_tb.sv]
// Self-checking testbench for the masked one-bit decoder: a directed table
// and random decode runs, each checked against a predictor written here.
// Depends on mobd_pkg and the masked_one_bit_decoder RTL.
`timescale 1ns / 1ps

module masked_one_bit_decoder_tb;

   // Sizes taken from the package.
   localparam int ORDER      = mobd_pkg::ORDER;
   localparam int NUM_SHARES = mobd_pkg::NUM_SHARES;
   localparam int TABLE_LOG  = mobd_pkg::TABLE_LOG;
   localparam int TABLE_BITS = mobd_pkg::TABLE_BITS;
   localparam int WORD_BITS  = mobd_pkg::WORD_BITS;
   localparam int NUM_WORDS  = mobd_pkg::NUM_WORDS;
   localparam int SLICE_BITS = mobd_pkg::SLICE_BITS;
   localparam int SHARE_W    = mobd_pkg::SHARE_W;
   localparam int OUT_IDX_W  = mobd_pkg::OUT_IDX_W;
   localparam int BOOL_W     = mobd_pkg::BOOL_W;
   localparam int REQ_DATA_W = mobd_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = mobd_pkg::RSP_DATA_W;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES  = 40;
   localparam int TARGET_ITEMS  = 230;
   localparam int RUN_WORDS     = ORDER * NUM_WORDS * ORDER + ORDER;

   // Table share zero after reset: its middle half is set.
   localparam logic [TABLE_BITS-1:0] MID_HALF =
      ({TABLE_BITS{1'b1}} >> (TABLE_BITS / 2)) << (TABLE_BITS / 4);
   localparam logic [WORD_BITS-1:0] SLICE_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - SLICE_BITS);

   typedef enum logic [1:0] {LOADING, REFRESHING, MASKING} decode_phase_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] idx;
      logic [BOOL_W-1:0]    share;
      logic                 is_last;
   } bool_result_type;

   typedef struct {
      logic              kind;
      logic [SHARE_W-1:0] share;
      logic [WORD_BITS-1:0] word;
      bit                typed;
      logic [BOOL_W-1:0] typed_share;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [SHARE_W-1:0]    csr_data;

   // Predictor state.
   logic [SHARE_W-1:0]    modulus_q;
   logic [TABLE_LOG-1:0]  switched [NUM_SHARES];
   logic [TABLE_BITS-1:0] tbl_row [NUM_SHARES];
   logic [WORD_BITS-1:0]  bit_acc [NUM_SHARES];
   decode_phase_type      dec_phase;
   int                    word_cnt;
   int                    row_cnt;
   int                    round_cnt;
   bool_result_type       decoded_shares [NUM_SHARES];

   bool_result_type       pending_shares [$];
   stim_row_type          directed_rows [$];

   bit                    no_gaps;
   int                    accepted_requests;
   int                    stray_requests;
   int                    predicted_shares;
   int                    shares_checked;
   int                    decode_runs;
   int                    modulus_writes;
   int                    mismatches;
   int                    cycle_count;

   masked_one_bit_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Modulus switch: round the share onto the table positions.
   function automatic logic [TABLE_LOG-1:0] switch_share(input logic [SHARE_W-1:0] x,
                                                         input logic [SHARE_W-1:0] q);
      longint unsigned num;
      longint unsigned den;
      den = 2 * longint'(q);
      if (den == 0) begin
         return '0;
      end
      num = (longint'(x) << (TABLE_LOG + 1)) + q;
      return TABLE_LOG'(num / den);
   endfunction

   // Rotate every table share right by the given amount.
   function automatic void rotate_rows(input logic [TABLE_LOG-1:0] amt);
      logic [2*TABLE_BITS-1:0] wide;
      for (int i = 0; i < NUM_SHARES; i++) begin
         wide = {tbl_row[i], tbl_row[i]} >> amt;
         tbl_row[i] = wide[TABLE_BITS-1:0];
      end
   endfunction

   // Return the predictor to its start of run.
   function automatic void clear_decoder();
      for (int i = 0; i < NUM_SHARES; i++) begin
         switched[i] = '0;
         tbl_row[i]  = '0;
         bit_acc[i]  = '0;
      end
      tbl_row[0] = MID_HALF;
      dec_phase  = LOADING;
      word_cnt   = 0;
      row_cnt    = 0;
      round_cnt  = 0;
   endfunction

   // Advance the predictor by one request; returns how many shares it emits.
   function automatic int decode_step(input logic kind, input logic [SHARE_W-1:0] share_in,
                                      input logic [WORD_BITS-1:0] word_in);
      logic [TABLE_LOG-1:0] pos;
      if ((dec_phase == LOADING && kind != mobd_pkg::REQ_SHARE) ||
          (dec_phase != LOADING && kind != mobd_pkg::REQ_RANDOM)) begin
         stray_requests++;
         return 0;
      end
      accepted_requests++;
      if (dec_phase == LOADING) begin
         switched[word_cnt] = switch_share(share_in, modulus_q);
         word_cnt++;
         if (word_cnt == NUM_SHARES) begin
            word_cnt  = 0;
            row_cnt   = 0;
            round_cnt = 0;
            rotate_rows(switched[0]);
            dec_phase = REFRESHING;
         end
         return 0;
      end
      if (dec_phase == REFRESHING) begin
         tbl_row[row_cnt][word_cnt*WORD_BITS +: SLICE_BITS] ^= word_in & SLICE_MASK;
         tbl_row[ORDER][word_cnt*WORD_BITS +: SLICE_BITS] ^= word_in & SLICE_MASK;
         word_cnt++;
         if (word_cnt == NUM_WORDS) begin
            word_cnt = 0;
            row_cnt++;
            if (row_cnt == ORDER) begin
               row_cnt = 0;
               round_cnt++;
               if (round_cnt < ORDER) begin
                  rotate_rows(switched[round_cnt]);
               end else begin
                  // Pick each share's bit at the last switched position.
                  pos = switched[ORDER];
                  for (int i = 0; i < NUM_SHARES; i++) begin
                     bit_acc[i] = {{(WORD_BITS-1){1'b0}}, tbl_row[i][pos]};
                  end
                  round_cnt = 0;
                  dec_phase = MASKING;
               end
            end
         end
         return 0;
      end
      // Masking: word j goes into boolean share j and the last share.
      bit_acc[word_cnt] ^= word_in;
      bit_acc[ORDER] ^= word_in;
      word_cnt++;
      if (word_cnt < ORDER) begin
         return 0;
      end
      for (int i = 0; i < NUM_SHARES; i++) begin
         decoded_shares[i].idx     = i[OUT_IDX_W-1:0];
         decoded_shares[i].share   = bit_acc[i][BOOL_W-1:0];
         decoded_shares[i].is_last = (i == ORDER);
      end
      clear_decoder();
      decode_runs++;
      return NUM_SHARES;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void add_row(input logic kind, input logic [SHARE_W-1:0] share_in,
                                   input logic [WORD_BITS-1:0] word_in, input bit typed,
                                   input logic [BOOL_W-1:0] typed_share);
      stim_row_type r;
      r.kind        = kind;
      r.share       = share_in;
      r.word        = word_in;
      r.typed       = typed;
      r.typed_share = typed_share;
      directed_rows.push_back(r);
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(0, WORD_BITS - 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Mostly shares below the modulus, with the field extremes mixed in.
   function automatic logic [SHARE_W-1:0] pick_share(input logic [SHARE_W-1:0] q);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return SHARE_W'($urandom_range(0, (1 << SHARE_W) - 1));
         default: begin
            if (q == 0) begin
               return SHARE_W'($urandom_range(0, (1 << SHARE_W) - 1));
            end
            return SHARE_W'($urandom_range(0, q - 1));
         end
      endcase
   endfunction

   function automatic logic [SHARE_W-1:0] pick_modulus(input int n);
      case (n % 6)
         0: return '1;
         1: return '0;
         2: return 12'd1;
         3: return 12'd2;
         4: return SHARE_W'($urandom_range(2, (1 << SHARE_W) - 1));
         default: return mobd_pkg::MODULUS_RESET;
      endcase
   endfunction

   // Present one request, wait for its handshake, then record what it predicts.
   task automatic send_request(input logic kind, input logic [SHARE_W-1:0] share_in,
                               input logic [WORD_BITS-1:0] word_in, input bit typed,
                               input logic [BOOL_W-1:0] typed_share);
      int gap;
      int n;
      bool_result_type r;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - SHARE_W - WORD_BITS){1'b0}}, word_in, share_in};
      do @(posedge clock); while (!req_tready);
      n = decode_step(kind, share_in, word_in);
      for (int i = 0; i < n; i++) begin
         r = decoded_shares[i];
         if (typed) begin
            r.share = typed_share;
         end
         pending_shares.push_back(r);
         predicted_shares++;
      end
   endtask

   // Occasionally slip in a request of the kind the current phase ignores.
   task automatic maybe_stray(input logic kind);
      if ($urandom_range(0, 9) == 0) begin
         send_request(kind, SHARE_W'($urandom_range(0, (1 << SHARE_W) - 1)), pick_word(),
                      1'b0, '0);
      end
   endtask

   // Let the decoder drain and go quiet, then write the modulus.
   task automatic write_modulus(input logic [SHARE_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_shares.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      modulus_q = value;
      modulus_writes++;
   endtask

   // One well-formed decode run with random content and stray requests.
   task automatic random_run();
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < NUM_SHARES; k++) begin
         maybe_stray(mobd_pkg::REQ_RANDOM);
         send_request(mobd_pkg::REQ_SHARE, pick_share(modulus_q), pick_word(), 1'b0, '0);
      end
      for (int k = 0; k < RUN_WORDS; k++) begin
         maybe_stray(mobd_pkg::REQ_SHARE);
         send_request(mobd_pkg::REQ_RANDOM, SHARE_W'($urandom_range(0, (1 << SHARE_W) - 1)),
                      pick_word(), 1'b0, '0);
      end
   endtask

   // Result side: random stalls, each result checked against the oldest prediction.
   initial begin : result_sink
      int stall;
      int taken;
      bit steady;
      bool_result_type got;
      bool_result_type want;
      taken  = 0;
      steady = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 8 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         stall = steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         got.idx     = rsp_tdata[OUT_IDX_W-1:0];
         got.share   = rsp_tdata[OUT_IDX_W +: BOOL_W];
         got.is_last = rsp_tlast;
         if (pending_shares.size() == 0) begin
            report_mismatch($sformatf("unexpected result, index %0d share %h",
                                      got.idx, got.share));
         end else begin
            want = pending_shares.pop_front();
            shares_checked++;
            if (got.idx != want.idx) begin
               report_mismatch($sformatf("share_index %0d, wanted %0d", got.idx, want.idx));
            end
            if (got.share != want.share) begin
               report_mismatch($sformatf("bool_share %h at index %0d, wanted %h",
                                         got.share, want.idx, want.share));
            end
            if (got.is_last != want.is_last) begin
               report_mismatch($sformatf("last %0d at index %0d, wanted %0d",
                                         got.is_last, want.idx, want.is_last));
            end
         end
      end
   end

   // Give up when the run stops making progress.
   initial begin : watchdog
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ERROR: run did not finish within %0d cycles", $time, cycle_count);
            $display("masked_one_bit_decoder regression: fail");
            $finish;
         end
      end
   end

   // Reset, directed table, random runs, drain and verdict.
   initial begin : stimulus
      int run_idx;
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      req_tuser         = mobd_pkg::REQ_SHARE;
      rsp_tready        = 1'b0;
      csr_valid         = 1'b0;
      csr_data          = '0;
      no_gaps           = 1'b0;
      accepted_requests = 0;
      stray_requests    = 0;
      predicted_shares  = 0;
      shares_checked    = 0;
      decode_runs       = 0;
      modulus_writes    = 0;
      mismatches        = 0;
      modulus_q         = mobd_pkg::MODULUS_RESET;
      clear_decoder();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero shares switch to zero, so every rotation leaves the table alone.
      // A stray random word during loading is ignored.
      add_row(mobd_pkg::REQ_SHARE, 12'd0, 64'd0, 1'b0, '0);
      add_row(mobd_pkg::REQ_RANDOM, 12'hFFF, '1, 1'b0, '0);
      add_row(mobd_pkg::REQ_SHARE, 12'd0, 64'd0, 1'b0, '0);
      add_row(mobd_pkg::REQ_SHARE, 12'd0, 64'd0, 1'b0, '0);
      add_row(mobd_pkg::REQ_SHARE, 12'd0, '1, 1'b0, '0);
      // All-ones refresh words, with a stray share at the top of its range.
      add_row(mobd_pkg::REQ_RANDOM, 12'd0, '1, 1'b0, '0);
      add_row(mobd_pkg::REQ_SHARE, 12'hFFF, '1, 1'b0, '0);
      for (int k = 1; k < ORDER * NUM_WORDS * ORDER; k++) begin
         add_row(mobd_pkg::REQ_RANDOM, 12'hFFF, '1, 1'b0, '0);
      end
      // Every row ends up inverted, so each picked bit is one; all-ones masks
      // then leave 0xFFFE in every boolean share.
      add_row(mobd_pkg::REQ_RANDOM, 12'd0, '1, 1'b0, '0);
      add_row(mobd_pkg::REQ_RANDOM, 12'd0, '1, 1'b0, '0);
      add_row(mobd_pkg::REQ_RANDOM, 12'd0, '1, 1'b1, 16'hFFFE);
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].kind, directed_rows[i].share, directed_rows[i].word,
                      directed_rows[i].typed, directed_rows[i].typed_share);
      end

      // Random runs; every other one starts with a new modulus.
      run_idx = 0;
      while ((accepted_requests + stray_requests) < TARGET_ITEMS) begin
         if (run_idx % 2 == 0) begin
            write_modulus(pick_modulus(run_idx / 2));
         end
         random_run();
         run_idx++;
      end

      req_tvalid <= 1'b0;
      while (pending_shares.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d decode runs: %0d requests taken, %0d ignored by phase.",
               decode_runs, accepted_requests, stray_requests);
      $display("Checked %0d boolean shares across %0d modulus writes.",
               shares_checked, modulus_writes);
      if (mismatches == 0) begin
         $display("masked_one_bit_decoder regression: pass");
      end else begin
         $display("masked_one_bit_decoder regression: fail");
      end
      $finish;
   end

endmodule
